### sv/b64enc_pkg.sv
package b64enc_pkg;

    localparam int QUEUE_DEPTH = 2;

    // Character index: 0..63 are alphabet entries, 64 is the '=' pad
    localparam int CODE_W = 7;
    localparam logic [CODE_W-1:0] PAD_CODE = 7'd64;

    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2
    } group_pos_t;

    // One input byte worth of output characters
    typedef struct packed {
        logic                   fin;     // group ends the message
        logic [1:0]             cnt;     // number of characters minus one
        logic [3:0][CODE_W-1:0] codes;   // codes[0] goes out first
    } b64_group_t;

    function automatic logic [7:0] b64_ascii(input logic [CODE_W-1:0] code);
        logic [7:0] c;
        begin
            c = {1'b0, code};
            if (code < 7'd26) begin
                b64_ascii = 8'h41 + c;
            end else if (code < 7'd52) begin
                b64_ascii = 8'h61 + c - 8'd26;
            end else if (code < 7'd62) begin
                b64_ascii = 8'h30 + c - 8'd52;
            end else if (code == 7'd62) begin
                b64_ascii = 8'h2B;
            end else if (code == 7'd63) begin
                b64_ascii = 8'h2F;
            end else begin
                b64_ascii = 8'h3D;
            end
        end
    endfunction

endpackage

### sv/base64_encoder_core.sv
// An accepted byte is first written into the group queue; its first character is then loaded
// into the output register that drives m_tdata. One character per cycle leaves that register
// while m_tready is high; a group of three bytes yields four characters.
// s_tready drops only when the group queue (QUEUE_DEPTH entries) is full.
// Reset (aresetn low, synchronous) empties the queue and output, starts a new message.
module base64_encoder_core #(
    parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,    // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_char
    output logic       m_tlast     // last_char
);
    import b64enc_pkg::*;

    b64_group_t group_in;
    b64_group_t group_head;
    logic       q_not_full;
    logic       q_not_empty;
    logic       q_pop;
    logic       accept;

    assign s_tready = q_not_full;
    assign accept   = s_tvalid && q_not_full;

    b64enc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .accept     (accept),
        .group_out  (group_in)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (group_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (group_head)
    );

    b64enc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (group_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

### sv/b64enc_front.sv
module b64enc_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             data_byte,
    input  logic                   final_byte,
    input  logic                   accept,
    output b64enc_pkg::b64_group_t group_out
);
    import b64enc_pkg::*;

    group_pos_t pos_reg, pos_next;
    logic [3:0] left_reg, left_next;

    always_comb begin
        group_out = '0;
        pos_next  = pos_reg;
        left_next = left_reg;
        group_out.fin = final_byte;
        case (pos_reg)
            POS_SECOND: begin
                group_out.codes[0] = {1'b0, left_reg[1:0], data_byte[7:4]};
                if (final_byte) begin
                    group_out.codes[1] = {1'b0, data_byte[3:0], 2'b00};
                    group_out.codes[2] = PAD_CODE;
                    group_out.cnt      = 2'd2;
                    pos_next  = POS_FIRST;
                    left_next = 4'd0;
                end else begin
                    group_out.cnt = 2'd0;
                    pos_next  = POS_THIRD;
                    left_next = data_byte[3:0];
                end
            end
            POS_THIRD: begin
                group_out.codes[0] = {1'b0, left_reg, data_byte[7:6]};
                group_out.codes[1] = {1'b0, data_byte[5:0]};
                group_out.cnt      = 2'd1;
                pos_next  = POS_FIRST;
                left_next = 4'd0;
            end
            default: begin
                group_out.codes[0] = {1'b0, data_byte[7:2]};
                if (final_byte) begin
                    group_out.codes[1] = {1'b0, data_byte[1:0], 4'b0000};
                    group_out.codes[2] = PAD_CODE;
                    group_out.codes[3] = PAD_CODE;
                    group_out.cnt      = 2'd3;
                    pos_next  = POS_FIRST;
                    left_next = 4'd0;
                end else begin
                    group_out.cnt = 2'd0;
                    pos_next  = POS_SECOND;
                    left_next = {2'b00, data_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_FIRST;
            left_reg <= 4'd0;
        end else if (accept) begin
            pos_reg  <= pos_next;
            left_reg <= left_next;
        end
    end

    // A final byte always closes the group
    a_fin_resets_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && final_byte |=> pos_reg == POS_FIRST && left_reg == 4'd0)
        else $error("group position not cleared after final byte");

endmodule

### sv/b64enc_queue.sv
module b64enc_queue #(
    parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  b64enc_pkg::b64_group_t push_data,
    output logic                   not_full,
    input  logic                   pop,
    output logic                   not_empty,
    output b64enc_pkg::b64_group_t head
);
    import b64enc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64_group_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full  = count_reg != FULL_CNT;
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT && !(push && !not_full) && !(pop && !not_empty))
        else $error("queue overflow or underflow");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count out of step with pushes");

endmodule

### sv/b64enc_back.sv
module b64enc_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_not_empty,
    input  b64enc_pkg::b64_group_t q_head,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);
    import b64enc_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       load;
    logic       end_of_group;

    assign load         = !valid_reg || m_tready;
    assign end_of_group = idx_reg == q_head.cnt;
    assign q_pop        = load && q_not_empty && end_of_group;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = q_not_empty;
            if (q_not_empty) begin
                data_next = b64_ascii(q_head.codes[idx_reg]);
                last_next = q_head.fin && end_of_group;
                idx_next  = end_of_group ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    // Mid-group index means the group is still at the queue head
    a_idx_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd0 |-> q_not_empty && idx_reg <= q_head.cnt)
        else $error("character index outside current group");

    a_pop_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> idx_reg == 2'd0)
        else $error("index not rewound after group pop");

endmodule
